// File: src/npr_pkg.sv
package npr_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned OUT_DATA_W = 152;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = 5'd31;
  localparam logic [COUNT_W-1:0] HEADER_LEN  = 5'd4;
  localparam logic [COUNT_W-1:0] ADDRESS_LEN = 5'd12;
  localparam logic [COUNT_W-1:0] MAPPING_LEN = 5'd16;

  // byte positions where each captured word starts
  localparam logic [COUNT_W-1:0] POS_VERSION  = 5'd0;
  localparam logic [COUNT_W-1:0] POS_OPCODE   = 5'd1;
  localparam logic [COUNT_W-1:0] POS_EPOCH    = 5'd4;
  localparam logic [COUNT_W-1:0] POS_MIDDLE   = 5'd8;
  localparam logic [COUNT_W-1:0] POS_LIFETIME = 5'd12;

  localparam int unsigned RESP_BIT = 7;

  typedef enum logic [6:0] {
    OP_ADDRESS = 7'h00,
    OP_UDP     = 7'h01,
    OP_TCP     = 7'h02
  } opcode_t;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_TRUNCATED    = 3'd1,
    ERR_BAD_VERSION  = 3'd2,
    ERR_NOT_RESPONSE = 3'd3,
    ERR_BAD_OPCODE   = 3'd4
  } err_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_ADDRESS = 2'd1,
    KIND_MAPPING = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PROTO_NONE = 2'd0,
    PROTO_UDP  = 2'd1,
    PROTO_TCP  = 2'd2
  } proto_t;

  typedef struct packed {
    logic        parse_ok;
    err_t        error_code;
    kind_t       msg_kind;
    proto_t      map_protocol;
    logic [15:0] result_code;
    logic [31:0] epoch_seconds;
    logic [31:0] external_address;
    logic [15:0] internal_port;
    logic [15:0] external_port;
    logic [31:0] mapping_lifetime;
  } answer_t;

endpackage

// File: src/natpmp_response_parser.sv
// the result for the transaction carrying the last byte goes to the output register,
// or to the skid register while the output register is held; throughput: one byte
//   per cycle while in_tready is high, and the skid register holds one extra result
// reset: synchronous active-low rst_n clears the byte count, captured fields,
//   expected_version (to zero) and the valid flags of both output stages
module natpmp_response_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration: expected_version
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [7:0]                      cfg_data,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] msg_byte
  input  logic                            in_tlast,   // last_byte
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // from bit 0 up: parse_ok, error_code(3), map_protocol(2), result_code(16),
  // epoch_seconds(32), external_address(32), internal_port(16),
  // external_port(16), mapping_lifetime(32), zero fill(2)
  output logic [npr_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [1:0]                      out_tuser   // msg_kind
);
  import npr_pkg::*;

  // configuration register
  logic [BYTE_W-1:0] exp_version_r;

  // capture state, one register per field of the message
  logic [COUNT_W-1:0] byte_count_r,    byte_count_nxt;
  logic               version_bad_r,   version_bad_nxt;
  logic [7:0]         opcode_byte_r,   opcode_byte_nxt;
  logic [15:0]        result_word_r,   result_word_nxt;
  logic [31:0]        epoch_word_r,    epoch_word_nxt;
  logic [31:0]        middle_word_r,   middle_word_nxt;
  logic [31:0]        lifetime_word_r, lifetime_word_nxt;

  // output register plus skid register
  answer_t out_data_r,  skid_data_r;
  logic    out_valid_r, skid_valid_r;

  logic    in_fire;
  logic    res_fire;
  answer_t res;
  logic [6:0] op;

  assign cfg_ready = 1'b1;
  // stall input only once the skid register is holding a result
  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign res_fire  = in_fire && in_tlast;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_version_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      exp_version_r <= cfg_data;
    end
  end

  // capture the current byte at its position; big-endian words shift in
  always_comb begin
    byte_count_nxt    = byte_count_r;
    version_bad_nxt   = version_bad_r;
    opcode_byte_nxt   = opcode_byte_r;
    result_word_nxt   = result_word_r;
    epoch_word_nxt    = epoch_word_r;
    middle_word_nxt   = middle_word_r;
    lifetime_word_nxt = lifetime_word_r;
    if (byte_count_r != COUNT_MAX) begin
      byte_count_nxt = byte_count_r + 5'd1;
    end
    priority if (byte_count_r == POS_VERSION) begin
      version_bad_nxt = (in_tdata != exp_version_r);
    end else if (byte_count_r == POS_OPCODE) begin
      opcode_byte_nxt = in_tdata;
    end else if (byte_count_r < POS_EPOCH) begin
      result_word_nxt = {result_word_r[7:0], in_tdata};
    end else if (byte_count_r < POS_MIDDLE) begin
      epoch_word_nxt = {epoch_word_r[23:0], in_tdata};
    end else if (byte_count_r < POS_LIFETIME) begin
      middle_word_nxt = {middle_word_r[23:0], in_tdata};
    end else if (byte_count_r < MAPPING_LEN) begin
      lifetime_word_nxt = {lifetime_word_r[23:0], in_tdata};
    end else begin
      // bytes past the body are ignored
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || res_fire) begin
      // the last byte closes the message, start clean for the next one
      byte_count_r    <= '0;
      version_bad_r   <= 1'b0;
      opcode_byte_r   <= '0;
      result_word_r   <= '0;
      epoch_word_r    <= '0;
      middle_word_r   <= '0;
      lifetime_word_r <= '0;
    end else if (in_fire) begin
      byte_count_r    <= byte_count_nxt;
      version_bad_r   <= version_bad_nxt;
      opcode_byte_r   <= opcode_byte_nxt;
      result_word_r   <= result_word_nxt;
      epoch_word_r    <= epoch_word_nxt;
      middle_word_r   <= middle_word_nxt;
      lifetime_word_r <= lifetime_word_nxt;
    end
  end

  // classify from the capture state including the last byte
  assign op = opcode_byte_nxt[6:0];

  always_comb begin
    res = '0;
    res.error_code = ERR_NONE;
    res.msg_kind = KIND_NONE;
    res.map_protocol = PROTO_NONE;
    priority if (byte_count_nxt < HEADER_LEN) begin
      res.error_code = ERR_TRUNCATED;
    end else if (version_bad_nxt) begin
      res.error_code = ERR_BAD_VERSION;
    end else if (!opcode_byte_nxt[RESP_BIT]) begin
      res.error_code = ERR_NOT_RESPONSE;
    end else begin
      res.result_code = result_word_nxt;
      priority if (op == OP_ADDRESS) begin
        if (byte_count_nxt < ADDRESS_LEN) begin
          res.error_code = ERR_TRUNCATED;
        end else begin
          res.parse_ok         = 1'b1;
          res.msg_kind         = KIND_ADDRESS;
          res.epoch_seconds    = epoch_word_nxt;
          res.external_address = middle_word_nxt;
        end
      end else if (op == OP_UDP || op == OP_TCP) begin
        if (byte_count_nxt < MAPPING_LEN) begin
          res.error_code = ERR_TRUNCATED;
        end else begin
          res.parse_ok         = 1'b1;
          res.msg_kind         = KIND_MAPPING;
          res.map_protocol     = (op == OP_UDP) ? PROTO_UDP : PROTO_TCP;
          res.epoch_seconds    = epoch_word_nxt;
          res.internal_port    = middle_word_nxt[31:16];
          res.external_port    = middle_word_nxt[15:0];
          res.mapping_lifetime = lifetime_word_nxt;
        end
      end else begin
        res.error_code = ERR_BAD_OPCODE;
      end
    end
  end

  // output stage: a result goes straight to the output register when it is
  // free or draining, otherwise it parks in the skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_tready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (res_fire) begin
      if (!out_valid_r || out_tready) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_tready) begin
        out_data_r <= skid_data_r;
      end
    end else if (res_fire) begin
      if (!out_valid_r || out_tready) begin
        out_data_r <= res;
      end else begin
        skid_data_r <= res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_data_r.msg_kind;
  assign out_tdata  = {2'b00,
                       out_data_r.mapping_lifetime,
                       out_data_r.external_port,
                       out_data_r.internal_port,
                       out_data_r.external_address,
                       out_data_r.epoch_seconds,
                       out_data_r.result_code,
                       out_data_r.map_protocol,
                       out_data_r.error_code,
                       out_data_r.parse_ok};

endmodule
